FILE: rtl/kwlex_pkg.sv
// Shared types and constants for the keyword lexer: token kinds, payload
// structs, character codes, keyword table and byte helpers. No dependencies.
package kwlex_pkg;

  // Fixed payload widths of the channels
  localparam int unsigned KindW   = 4;
  localparam int unsigned RowW    = 16;
  localparam int unsigned ColW    = 16;
  localparam int unsigned TextW   = 64;
  localparam int unsigned TextLenW = 10;

  // Result queue geometry
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef enum logic [KindW-1:0] {
    KIND_UNKNOWN = 4'd0,
    KIND_COMMA   = 4'd1,
    KIND_LPAREN  = 4'd2,
    KIND_RPAREN  = 4'd3,
    KIND_ASSIGN  = 4'd4,
    KIND_NEQ     = 4'd5,
    KIND_DO      = 4'd6,
    KIND_END     = 4'd7,
    KIND_PRED    = 4'd8,
    KIND_PROGRAM = 4'd9,
    KIND_RESULT  = 4'd10,
    KIND_SUCC    = 4'd11,
    KIND_WHILE   = 4'd12,
    KIND_IDENT   = 4'd13,
    KIND_INT     = 4'd14,
    KIND_EOF     = 4'd15
  } kind_e;

  typedef struct packed {
    logic [7:0] ch;
  } src_word_t;

  typedef struct packed {
    kind_e               kind;
    logic [RowW-1:0]     row;
    logic [ColW-1:0]     col;
    logic [TextW-1:0]    text;
    logic [TextLenW-1:0] text_length;
    logic                last;
  } token_t;

  // Up to two tokens pushed into the result queue per source byte
  typedef struct packed {
    logic   en0;
    logic   en1;
    token_t tok0;
    token_t tok1;
  } tok_push_t;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_UPX   = 8'h58;

  // Tab moves the column on by this much in total
  localparam logic [3:0] TAB_STEP = 4'd8;

  // Keywords in upper case, first character in the low byte
  localparam int unsigned KwCount = 7;
  localparam logic [TextW-1:0] KW_TEXT [KwCount] = '{
    64'h0000_0000_0000_4F44,  // DO
    64'h0000_0000_0044_4E45,  // END
    64'h0000_0000_4445_5250,  // PRED
    64'h004D_4152_474F_5250,  // PROGRAM
    64'h0000_544C_5553_4552,  // RESULT
    64'h0000_0000_4343_5553,  // SUCC
    64'h0000_0045_4C49_4857   // WHILE
  };
  localparam logic [2:0] KW_LEN [KwCount] = '{
    3'd2, 3'd3, 3'd4, 3'd7, 3'd6, 3'd4, 3'd5
  };

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'h20) : c;
  endfunction

endpackage

FILE: rtl/kwlex_chan_if.sv
// Valid/ready channel interface carrying one payload word per handshake.
// Payload type is set per instance; no other dependencies.
interface kwlex_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/kwlex_classify.sv
// Word classifier: keyword match, identifier, integer or unknown.
// Depends on kwlex_pkg.
module kwlex_classify #(
  parameter int unsigned WORD_CHARS      = 8,
  parameter int unsigned MAX_WORD_LENGTH = 1023
) (
  input  logic [WORD_CHARS*8-1:0]               text_i,
  input  logic [$clog2(MAX_WORD_LENGTH+1)-1:0]  len_i,
  input  logic                                  digits_i,
  output kwlex_pkg::kind_e                      kind_o
);
  localparam int unsigned LenW = $clog2(MAX_WORD_LENGTH + 1);

  logic [WORD_CHARS*8-1:0] upper;
  logic                    found;

  always_comb begin
    for (int i = 0; i < WORD_CHARS; i++) begin
      upper[i*8 +: 8] = kwlex_pkg::to_upper(text_i[i*8 +: 8]);
    end
  end

  always_comb begin
    found  = 1'b0;
    kind_o = kwlex_pkg::KIND_UNKNOWN;
    // bytes past the word length are zero, so a full-width compare is exact
    for (int k = 0; k < kwlex_pkg::KwCount; k++) begin
      if (!found && (len_i == LenW'(kwlex_pkg::KW_LEN[k]))
          && (kwlex_pkg::TextW'(upper) == kwlex_pkg::KW_TEXT[k])) begin
        found  = 1'b1;
        kind_o = kwlex_pkg::kind_e'(4'(int'(kwlex_pkg::KIND_DO) + k));
      end
    end
    if (!found) begin
      if (upper[7:0] == kwlex_pkg::CH_UPX) begin
        kind_o = kwlex_pkg::KIND_IDENT;
      end else if (digits_i) begin
        kind_o = kwlex_pkg::KIND_INT;
      end else begin
        kind_o = kwlex_pkg::KIND_UNKNOWN;
      end
    end
  end
endmodule

FILE: rtl/kwlex_tok_fifo.sv
// Small result queue: takes up to two tokens a cycle, gives one a cycle while the receiver is ready.
// Depends on kwlex_pkg and kwlex_chan_if.
module kwlex_tok_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  kwlex_pkg::tok_push_t  push_i,
  output logic                  room_o,
  kwlex_chan_if.source          token_o
);
  localparam int unsigned PtrW = kwlex_pkg::FifoPtrW;
  localparam int unsigned CntW = kwlex_pkg::FifoCntW;

  kwlex_pkg::token_t mem_q [kwlex_pkg::FifoDepth];
  logic [PtrW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              pop;

  assign token_o.valid   = (count_q != '0);
  assign token_o.payload = mem_q[head_q];
  assign pop             = token_o.valid && token_o.ready;
  assign room_o          = (count_q <= CntW'(kwlex_pkg::FifoDepth - 2));

  always_comb begin
    head_d  = head_q + PtrW'(pop);
    tail_d  = tail_q + PtrW'(push_i.en0) + PtrW'(push_i.en1);
    count_d = count_q + CntW'(push_i.en0) + CntW'(push_i.en1) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.en0) begin
      mem_q[tail_q] <= push_i.tok0;
    end
    if (push_i.en1) begin
      mem_q[tail_q + PtrW'(1)] <= push_i.tok1;
    end
  end
endmodule

FILE: rtl/kwlex_scan.sv
// Scanner: input word register, scan state and the per-byte step logic.
// Depends on kwlex_pkg, kwlex_chan_if and kwlex_classify.
module kwlex_scan #(
  parameter int unsigned WORD_CHARS      = 8,
  parameter int unsigned MAX_WORD_LENGTH = 1023,
  parameter int unsigned POSITION_BITS   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  kwlex_chan_if.sink            byte_i,
  input  logic                  room_i,
  output kwlex_pkg::tok_push_t  push_o
);
  localparam int unsigned LenW  = $clog2(MAX_WORD_LENGTH + 1);
  localparam int unsigned WTxtW = WORD_CHARS * 8;
  localparam int unsigned PosW  = POSITION_BITS;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_COLON,
    MODE_BANG,
    MODE_WORD
  } mode_e;

  function automatic logic [PosW-1:0] pos_add(input logic [PosW-1:0] v,
                                               input logic [3:0] d);
    logic [PosW:0] sum;
    sum = {1'b0, v} + (PosW+1)'(d);
    return sum[PosW] ? {PosW{1'b1}} : sum[PosW-1:0];
  endfunction

  // input word register
  logic       vld_q;
  logic [7:0] ch_q;
  logic       adv;

  // scan state
  mode_e            mode_q, mode_d;
  logic [PosW-1:0]  line_q, line_d, col_q, col_d, start_q, start_d;
  logic [WTxtW-1:0] text_q, text_d;
  logic [LenW-1:0]  len_q, len_d;
  logic             digits_q, digits_d;

  // idle-mode handling of the current byte
  mode_e            idl_mode;
  logic [PosW-1:0]  idl_line, idl_col, idl_start;
  logic [WTxtW-1:0] idl_text;
  logic [LenW-1:0]  idl_len;
  logic             idl_digits, idl_emit;
  kwlex_pkg::kind_e idl_kind;

  kwlex_pkg::kind_e word_kind, pre_kind;
  logic             pre_emit, use_idle, idle_out, valued;
  kwlex_pkg::token_t pre_tok, idl_tok;

  assign adv          = vld_q && room_i;
  assign byte_i.ready = !vld_q || room_i;

  kwlex_classify #(
    .WORD_CHARS      (WORD_CHARS),
    .MAX_WORD_LENGTH (MAX_WORD_LENGTH)
  ) u_classify (
    .text_i   (text_q),
    .len_i    (len_q),
    .digits_i (digits_q),
    .kind_o   (word_kind)
  );

  always_comb begin
    idl_mode   = MODE_IDLE;
    idl_line   = line_q;
    idl_col    = pos_add(col_q, 4'd1);
    idl_start  = start_q;
    idl_text   = '0;
    idl_len    = '0;
    idl_digits = 1'b1;
    idl_emit   = 1'b0;
    idl_kind   = kwlex_pkg::KIND_UNKNOWN;
    case (ch_q) inside
      kwlex_pkg::CH_NUL: begin
        idl_emit  = 1'b1;
        idl_kind  = kwlex_pkg::KIND_EOF;
        idl_line  = PosW'(1);
        idl_col   = PosW'(1);
        idl_start = '0;
      end
      kwlex_pkg::CH_CR, kwlex_pkg::CH_SPACE: begin
      end
      kwlex_pkg::CH_LF: begin
        idl_line = pos_add(line_q, 4'd1);
        idl_col  = PosW'(1);
      end
      kwlex_pkg::CH_TAB: idl_col = pos_add(col_q, kwlex_pkg::TAB_STEP);
      kwlex_pkg::CH_HASH: idl_mode = MODE_COMMENT;
      kwlex_pkg::CH_COMMA: begin
        idl_emit = 1'b1;
        idl_kind = kwlex_pkg::KIND_COMMA;
      end
      kwlex_pkg::CH_LPAR: begin
        idl_emit = 1'b1;
        idl_kind = kwlex_pkg::KIND_LPAREN;
      end
      kwlex_pkg::CH_RPAR: begin
        idl_emit = 1'b1;
        idl_kind = kwlex_pkg::KIND_RPAREN;
      end
      kwlex_pkg::CH_COLON: begin
        idl_mode  = MODE_COLON;
        idl_start = col_q;
      end
      kwlex_pkg::CH_BANG: begin
        idl_mode  = MODE_BANG;
        idl_start = col_q;
      end
      default: begin
        if (kwlex_pkg::is_alnum(ch_q)) begin
          idl_mode   = MODE_WORD;
          idl_start  = col_q;
          idl_text   = WTxtW'(ch_q);
          idl_len    = LenW'(1);
          idl_digits = kwlex_pkg::is_digit(ch_q);
        end else begin
          idl_emit = 1'b1;
          idl_kind = kwlex_pkg::KIND_UNKNOWN;
        end
      end
    endcase
  end

  always_comb begin
    mode_d   = mode_q;
    line_d   = line_q;
    col_d    = col_q;
    start_d  = start_q;
    text_d   = text_q;
    len_d    = len_q;
    digits_d = digits_q;
    pre_emit = 1'b0;
    pre_kind = kwlex_pkg::KIND_UNKNOWN;
    use_idle = 1'b0;
    unique case (mode_q) inside
      MODE_COMMENT: begin
        // drop everything up to the newline or end of source
        use_idle = (ch_q == kwlex_pkg::CH_NUL) || (ch_q == kwlex_pkg::CH_LF);
      end
      MODE_COLON, MODE_BANG: begin
        pre_emit = 1'b1;
        if (ch_q == kwlex_pkg::CH_EQ) begin
          col_d    = pos_add(col_q, 4'd1);
          pre_kind = (mode_q == MODE_COLON) ? kwlex_pkg::KIND_ASSIGN : kwlex_pkg::KIND_NEQ;
          mode_d   = MODE_IDLE;
        end else begin
          pre_kind = kwlex_pkg::KIND_UNKNOWN;
          use_idle = 1'b1;
        end
      end
      MODE_WORD: begin
        if (kwlex_pkg::is_alnum(ch_q)) begin
          col_d = pos_add(col_q, 4'd1);
          for (int i = 0; i < WORD_CHARS; i++) begin
            if (len_q == LenW'(i)) begin
              text_d[i*8 +: 8] = ch_q;
            end
          end
          if (len_q < LenW'(MAX_WORD_LENGTH)) begin
            len_d = len_q + LenW'(1);
          end
          digits_d = digits_q && kwlex_pkg::is_digit(ch_q);
        end else begin
          pre_emit = 1'b1;
          pre_kind = word_kind;
          use_idle = 1'b1;
        end
      end
      default: use_idle = 1'b1;
    endcase
    if (use_idle) begin
      mode_d   = idl_mode;
      line_d   = idl_line;
      col_d    = idl_col;
      start_d  = idl_start;
      text_d   = idl_text;
      len_d    = idl_len;
      digits_d = idl_digits;
    end
  end

  assign idle_out = use_idle && idl_emit;
  assign valued   = (pre_kind == kwlex_pkg::KIND_IDENT) || (pre_kind == kwlex_pkg::KIND_INT);

  always_comb begin
    pre_tok.kind        = pre_kind;
    pre_tok.row         = kwlex_pkg::RowW'(line_q);
    pre_tok.col         = kwlex_pkg::ColW'(start_q);
    pre_tok.text        = valued ? kwlex_pkg::TextW'(text_q) : '0;
    pre_tok.text_length = valued ? kwlex_pkg::TextLenW'(len_q) : '0;
    pre_tok.last        = !idle_out;

    idl_tok.kind        = idl_kind;
    idl_tok.row         = kwlex_pkg::RowW'(line_q);
    idl_tok.col         = kwlex_pkg::ColW'(col_q);
    idl_tok.text        = '0;
    idl_tok.text_length = '0;
    idl_tok.last        = 1'b1;

    push_o.en0  = adv && (pre_emit || idle_out);
    push_o.en1  = adv && pre_emit && idle_out;
    push_o.tok0 = pre_emit ? pre_tok : idl_tok;
    push_o.tok1 = idl_tok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= 1'b0;
      mode_q   <= MODE_IDLE;
      line_q   <= PosW'(1);
      col_q    <= PosW'(1);
      start_q  <= '0;
      text_q   <= '0;
      len_q    <= '0;
      digits_q <= 1'b1;
    end else begin
      if (byte_i.valid && byte_i.ready) begin
        vld_q <= 1'b1;
      end else if (adv) begin
        vld_q <= 1'b0;
      end
      if (adv) begin
        mode_q   <= mode_d;
        line_q   <= line_d;
        col_q    <= col_d;
        start_q  <= start_d;
        text_q   <= text_d;
        len_q    <= len_d;
        digits_q <= digits_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      ch_q <= byte_i.payload.ch;
    end
  end
endmodule

FILE: rtl/keyword_lexer_core.sv
// Top level of the keyword lexer: source-byte channel in, token channel out.
// Depends on kwlex_pkg, kwlex_chan_if, kwlex_scan and kwlex_tok_fifo.
//
// Usage:
//  - byte_i carries one source byte per word (payload.ch); byte 0 ends the
//    source, yields an end-of-source token and returns the scanner to row 1,
//    column 1 so the next byte starts a fresh source.
//  - token_o carries one token per word: kind, row and column of its first
//    byte, word text and length (identifiers and integers only), and a last
//    flag set on the final token caused by a given source byte.
//  - Path: a byte taken from byte_i waits in the input register while it is
//    scanned; its tokens are written into the token queue and leave on token_o.
//  - Throughput: one byte per cycle while token_o is ready and each byte yields
//    at most one token; a byte that yields two tokens (a word or lone ':'/'!'
//    closed by a punctuation byte, an unknown byte or byte 0) queues both, and
//    the single read port of the four-entry token queue gives them out one by one.
//  - Stalls: when token_o is held off the queue fills; byte_i.ready falls
//    while a byte waits in the input register and fewer than two queue
//    entries are free; nothing is dropped.
//  - Reset (rst_ni low, asynchronous) empties the queue and the input stage
//    and puts the scanner at row 1, column 1 outside any word or comment.
module keyword_lexer_core #(
  parameter int unsigned WORD_CHARS      = 8,
  parameter int unsigned MAX_WORD_LENGTH = 1023,
  parameter int unsigned POSITION_BITS   = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  kwlex_chan_if.sink   byte_i,
  kwlex_chan_if.source token_o
);

  // tokens produced by the scanner for the byte in its input register
  kwlex_pkg::tok_push_t push;
  // queue can take a full pair of tokens this cycle
  logic                 room;

  // Scan stage: hold one byte, advance the scan state only when the queue
  // can absorb every token the byte may cause.
  kwlex_scan #(
    .WORD_CHARS      (WORD_CHARS),
    .MAX_WORD_LENGTH (MAX_WORD_LENGTH),
    .POSITION_BITS   (POSITION_BITS)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_i),
    .room_i (room),
    .push_o (push)
  );

  // Result queue: decouple the scanner from a stalling receiver.
  kwlex_tok_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .token_o (token_o)
  );

endmodule
